>>> rtl/file_header_crc_checker_core_defines.svh
// assertion macros for the header checker rtl
`ifndef FILE_HEADER_CRC_CHECKER_CORE_DEFINES_SVH
`define FILE_HEADER_CRC_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTH

// checked property, off while reset is high
`define FHC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define FHC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define FHC_ASSERT(label, prop, msg)

`define FHC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> rtl/fchc_pkg.sv
// types, constants and the nibble crc table of the header checker
`timescale 1ns / 1ps

package fchc_pkg;

   localparam int IDX_W = 4;

   localparam logic [IDX_W-1:0] HDR_CRC_LO = 4'd12;
   localparam logic [IDX_W-1:0] HDR_LAST   = 4'd13;
   localparam logic [IDX_W-1:0] HDR_DONE   = 4'd14;
   localparam int               HDR_STORED = 13;

   localparam logic [15:0] NIB_TABLE [16] = '{
      16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
      16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
   };

   typedef struct packed {
      logic [7:0] byte_value;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  header_length;
      logic [7:0]  protocol_ver;
      logic [15:0] profile_ver;
      logic [31:0] payload_size;
      logic [31:0] type_tag;
      logic [15:0] stored_crc;
      logic [15:0] computed_crc;
      logic        crc_match;
   } rsp_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] byte_index;
   } trk_stat_type;

   // one reflected crc-16 step over four bits
   function automatic logic [15:0] nib_step(input logic [15:0] crc, input logic [3:0] nib);
      logic [15:0] shifted;
      shifted  = {4'h0, crc[15:4]};
      nib_step = shifted ^ NIB_TABLE[crc[3:0]] ^ NIB_TABLE[nib];
   endfunction

endpackage

>>> rtl/file_header_crc_checker_core.sv
// top level of the file header crc checker
`timescale 1ns / 1ps

// Header checker for a 14-byte fitness-file header. Bytes enter one per
// transfer on req_; frame_start marks header byte 0 and restarts the byte
// count and the crc (after reset the first byte is byte 0 even without it).
// Bytes 0 to 11 feed a CRC-16/ARC (reflected 0xA001, init 0) built as two
// 16-entry nibble table steps per byte. When byte 13 is taken one rsp_
// transfer carries the decoded fields, the stored and computed crc and a
// match flag; bytes after byte 13 and before a new start give nothing.
// Rate: one byte per clock sustained. A byte is registered on input and goes
// through the crc and capture logic once the result register is free or
// drains; byte 13 lands in the result register when it is processed, which
// raises rsp_valid. Only a held result (rsp_ready low) stalls the input.

`include "file_header_crc_checker_core_defines.svh"

module file_header_crc_checker_core import fchc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_type      in_data_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_type      rsp_data_ff;
   logic         advance;
   logic         proc_en;
   logic         req_fire;
   logic         hit_taken;
   rsp_type      trk_result;
   trk_stat_type trk_status;

   // the held byte moves on whenever the result register is free or drains
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign proc_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign hit_taken = proc_en && trk_status.hit;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? hit_taken : rsp_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   // header position, crc and field capture
   fchc_hdr_track u_track (
      .clock   (clock),
      .reset   (reset),
      .proc_en (proc_en),
      .item    (in_data_ff),
      .result  (trk_result),
      .status  (trk_status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_taken) begin
         rsp_data_ff <= trk_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result only comes from a byte 13 that was just processed
   `FHC_ASSERT(a_rsp_from_hit, $rose(rsp_valid_ff) |-> $past(hit_taken), "result without header end")

   // a processed final byte always lands in the result register
   `FHC_ASSERT(a_hit_lands, hit_taken |=> rsp_valid_ff, "header end lost")

   // input stalls only behind a full, held result
   `FHC_ASSERT(a_stall_cause, !req_ready |-> (rsp_valid_ff && !rsp_ready), "spurious input stall")

   // byte position never reaches the unused code fifteen
   `FHC_ASSERT_ALWAYS(a_idx_range, (reset || trk_status.byte_index != 4'd15), "index out of range")

endmodule

>>> rtl/fchc_crc_unit.sv
// crc-16 update over one byte as two nibble table steps, low nibble first
`timescale 1ns / 1ps

module fchc_crc_unit import fchc_pkg::*; (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);

   logic [15:0] crc_mid;

   assign crc_mid = nib_step(crc_in, data_in[3:0]);
   assign crc_out = nib_step(crc_mid, data_in[7:4]);

endmodule

>>> rtl/fchc_hdr_track.sv
// header byte position, running crc and captured header bytes
`timescale 1ns / 1ps

module fchc_hdr_track import fchc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         proc_en,
   input  req_type      item,
   output rsp_type      result,
   output trk_stat_type status
);

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] idx_eff;
   logic [15:0]      crc_ff;
   logic [15:0]      crc_base;
   logic [15:0]      crc_in;
   logic [7:0]       bytes_ff [HDR_STORED];
   logic             active;
   logic [15:0]      stored;

   // a start flag forces position zero
   assign idx_eff  = item.frame_start ? '0 : idx_ff;
   assign active   = (idx_eff < HDR_DONE);
   assign crc_base = (idx_eff == '0) ? 16'h0000 : crc_ff;
   assign idx_in   = (idx_eff == HDR_LAST) ? HDR_DONE : idx_eff + 4'd1;

   fchc_crc_unit u_crc (
      .crc_in  (crc_base),
      .data_in (item.byte_value),
      .crc_out (crc_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         crc_ff <= '0;
      end else if (proc_en && active) begin
         idx_ff <= idx_in;
         if (idx_eff < HDR_CRC_LO) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HDR_STORED; i++) begin
         if (proc_en && (idx_eff == IDX_W'(i))) begin
            bytes_ff[i] <= item.byte_value;
         end
      end
   end

   assign stored = {item.byte_value, bytes_ff[12]};

   always_comb begin
      result.header_length = bytes_ff[0];
      result.protocol_ver  = bytes_ff[1];
      result.profile_ver   = {bytes_ff[3], bytes_ff[2]};
      result.payload_size  = {bytes_ff[7], bytes_ff[6], bytes_ff[5], bytes_ff[4]};
      result.type_tag      = {bytes_ff[11], bytes_ff[10], bytes_ff[9], bytes_ff[8]};
      result.stored_crc    = stored;
      result.computed_crc  = crc_ff;
      result.crc_match     = (stored == crc_ff);
   end

   assign status.hit        = active && (idx_eff == HDR_LAST);
   assign status.byte_index = idx_ff;

endmodule
